### sv/ped_pkg.sv
// ----------------------------------------------------------------------------
// Percent escape decoder package
// Shared types, character codes and hex digit helpers.
// ----------------------------------------------------------------------------
package ped_pkg;

   localparam int CP_W       = 21;
   localparam int HELD_DEPTH = 5;
   localparam int MAX_BEATS  = 6;
   localparam int COUNT_W    = 3;

   localparam logic [CP_W-1:0] CH_PERCENT = 21'h000025;
   localparam logic [CP_W-1:0] CH_LOWER_U = 21'h000075;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_PCT  = 3'd1,
      PH_ONE  = 3'd2,
      PH_U    = 3'd3,
      PH_U1   = 3'd4,
      PH_U2   = 3'd5,
      PH_U3   = 3'd6
   } phase_type;

   typedef struct packed {
      logic [COUNT_W-1:0]             count;
      logic [MAX_BEATS-1:0][CP_W-1:0] cps;
   } burst_type;

   function automatic logic is_hex(input logic [CP_W-1:0] c);
      return (c >= 21'h30 && c <= 21'h39) || (c >= 21'h41 && c <= 21'h46) ||
             (c >= 21'h61 && c <= 21'h66);
   endfunction

   function automatic logic [3:0] hex_val(input logic [CP_W-1:0] c);
      logic [3:0] v;
      v = '0;
      if (c >= 21'h30 && c <= 21'h39) begin
         v = c[3:0];
      end else if ((c >= 21'h41 && c <= 21'h46) || (c >= 21'h61 && c <= 21'h66)) begin
         v = c[3:0] + 4'd9;
      end
      return v;
   endfunction

endpackage

### sv/ped_if.sv
// ----------------------------------------------------------------------------
// Percent escape decoder channels
// Valid/ready channels for input characters and output characters.
// ----------------------------------------------------------------------------
interface ped_req_if;
   logic                     valid;
   logic                     ready;
   logic [ped_pkg::CP_W-1:0] code_point;
   logic                     end_of_string;

   modport source (output valid, output code_point, output end_of_string, input ready);
   modport sink (input valid, input code_point, input end_of_string, output ready);
endinterface

interface ped_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [ped_pkg::CP_W-1:0] out_code_point;
   logic                     last_of_run;

   modport source (output valid, output out_code_point, output last_of_run, input ready);
   modport sink (input valid, input out_code_point, input last_of_run, output ready);
endinterface

### sv/ped_decode.sv
// ----------------------------------------------------------------------------
// Percent escape decoder step logic
// Escape state, held characters and the result list for one character.
// ----------------------------------------------------------------------------
module ped_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic [ped_pkg::CP_W-1:0] code_point,
   input  logic                     end_of_string,
   output ped_pkg::burst_type       burst
);
   import ped_pkg::*;

   phase_type                       phase_ff, phase_in, phase_mid;
   logic [HELD_DEPTH-1:0][CP_W-1:0] held_ff, held_in;

   always_comb begin
      case (phase_ff)
         PH_PCT:  phase_mid = (code_point == CH_LOWER_U) ? PH_U : PH_ONE;
         PH_ONE:  phase_mid = PH_IDLE;
         PH_U:    phase_mid = PH_U1;
         PH_U1:   phase_mid = PH_U2;
         PH_U2:   phase_mid = PH_U3;
         PH_U3:   phase_mid = PH_IDLE;
         default: phase_mid = (code_point == CH_PERCENT) ? PH_PCT : PH_IDLE;
      endcase
      phase_in = end_of_string ? PH_IDLE : phase_mid;
   end

   always_comb begin
      held_in     = held_ff;
      burst.count = '0;
      burst.cps   = '0;
      case (phase_ff)
         PH_PCT: begin
            held_in[1] = code_point;
         end
         PH_ONE: begin
            if (is_hex(held_ff[1]) && is_hex(code_point)) begin
               burst.cps[0] = CP_W'({hex_val(held_ff[1]), hex_val(code_point)});
               burst.count  = COUNT_W'(1);
            end else begin
               burst.cps[0] = held_ff[0];
               burst.cps[1] = held_ff[1];
               burst.cps[2] = code_point;
               burst.count  = COUNT_W'(3);
            end
         end
         PH_U: begin
            held_in[2] = code_point;
         end
         PH_U1: begin
            held_in[3] = code_point;
         end
         PH_U2: begin
            held_in[4] = code_point;
         end
         PH_U3: begin
            if (is_hex(held_ff[2]) && is_hex(held_ff[3]) && is_hex(held_ff[4]) &&
                is_hex(code_point)) begin
               burst.cps[0] = CP_W'({hex_val(held_ff[2]), hex_val(held_ff[3]),
                                     hex_val(held_ff[4]), hex_val(code_point)});
               burst.count  = COUNT_W'(1);
            end else begin
               for (int i = 0; i < HELD_DEPTH; i++) begin
                  burst.cps[i] = held_ff[i];
               end
               burst.cps[5] = code_point;
               burst.count  = COUNT_W'(6);
            end
         end
         default: begin
            if (code_point == CH_PERCENT) begin
               held_in[0] = code_point;
            end else begin
               burst.cps[0] = code_point;
               burst.count  = COUNT_W'(1);
            end
         end
      endcase

      // An open group at the end of the string is replayed as held.
      if (end_of_string && phase_mid != PH_IDLE) begin
         for (int i = 0; i < HELD_DEPTH; i++) begin
            burst.cps[i] = held_in[i];
         end
         case (phase_mid)
            PH_PCT:  burst.count = COUNT_W'(1);
            PH_ONE:  burst.count = COUNT_W'(2);
            PH_U:    burst.count = COUNT_W'(2);
            PH_U1:   burst.count = COUNT_W'(3);
            PH_U2:   burst.count = COUNT_W'(4);
            PH_U3:   burst.count = COUNT_W'(5);
            default: burst.count = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (step_en) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         held_ff <= held_in;
      end
   end

endmodule

### sv/ped_burst.sv
// ----------------------------------------------------------------------------
// Percent escape decoder output buffer
// Holds the results of one character and sends them one beat at a time.
// ----------------------------------------------------------------------------
module ped_burst (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  ped_pkg::burst_type burst,
   output logic               free,
   ped_rsp_if.source          rsp_chan
);
   import ped_pkg::*;

   logic [COUNT_W-1:0]             count_ff;
   logic [COUNT_W-1:0]             idx_ff;
   logic [MAX_BEATS-1:0][CP_W-1:0] cps_ff;
   logic                           last;
   logic                           take;

   assign last = (idx_ff == count_ff - COUNT_W'(1));
   assign take = rsp_chan.valid && rsp_chan.ready;
   assign free = (count_ff == '0) || (take && last);

   assign rsp_chan.valid          = (count_ff != '0);
   assign rsp_chan.out_code_point = cps_ff[idx_ff];
   assign rsp_chan.last_of_run    = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else if (load) begin
         count_ff <= burst.count;
         idx_ff   <= '0;
      end else if (take) begin
         if (last) begin
            count_ff <= '0;
            idx_ff   <= '0;
         end else begin
            idx_ff <= idx_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cps_ff <= burst.cps;
      end
   end

endmodule

### sv/percent_escape_decoder_core.sv
// A character is accepted into the input register; its result beats are loaded into
// the output buffer once it is free. Characters inside an open escape give no beats.
// Throughput: one character per cycle while each character gives at most one result
// and the receiver is ready. A character with several results holds the input side
// until its last beat is taken, as the output port sends one beat per cycle while ready.
// Reset clears the escape state, the input stage and the output buffer; held
// characters are not cleared.
// ----------------------------------------------------------------------------
// Percent escape decoder core
// Input register, escape decode step and output beat buffer.
// ----------------------------------------------------------------------------
module percent_escape_decoder_core (
   input  logic      clock,
   input  logic      reset,
   ped_req_if.sink   req_chan,
   ped_rsp_if.source rsp_chan
);
   import ped_pkg::*;

   logic            in_valid_ff;
   logic [CP_W-1:0] in_cp_ff;
   logic            in_eos_ff;
   logic            free;
   logic            step_en;
   burst_type       burst;

   assign step_en        = in_valid_ff && free;
   assign req_chan.ready = !in_valid_ff || step_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_cp_ff  <= req_chan.code_point;
         in_eos_ff <= req_chan.end_of_string;
      end
   end

   ped_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .step_en       (step_en),
      .code_point    (in_cp_ff),
      .end_of_string (in_eos_ff),
      .burst         (burst)
   );

   ped_burst u_burst (
      .clock    (clock),
      .reset    (reset),
      .load     (step_en),
      .burst    (burst),
      .free     (free),
      .rsp_chan (rsp_chan)
   );

endmodule

### sv/ped_checker.sv
// ----------------------------------------------------------------------------
// Percent escape decoder checker
// Port-level properties of the decoder core, bound to the core module.
// ----------------------------------------------------------------------------
module ped_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [ped_pkg::CP_W-1:0] out_code_point,
   input logic                     last_of_run
);
   import ped_pkg::*;

   // The output buffer is empty after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat offered right after reset");

   // A beat that is not the last of its run is followed by another.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !last_of_run) |=> rsp_valid)
      else $error("run of result beats broken off");

   // The input side only stalls behind pending result beats.
   assert property (@(posedge clock) disable iff (reset) !req_ready |-> rsp_valid)
      else $error("input stalled with no result pending");

   // A stalled result beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(out_code_point) && $stable(last_of_run)))
      else $error("stalled result beat changed");

endmodule

bind percent_escape_decoder_core ped_checker u_ped_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .out_code_point (rsp_chan.out_code_point),
   .last_of_run    (rsp_chan.last_of_run)
);

### verif/percent_escape_decoder_checker.sv
// ----------------------------------------------------------------------------
// Percent escape decoder checker
// Watches both channels, predicts the result beats of every accepted
// character and compares each delivered beat with the oldest prediction.
// ----------------------------------------------------------------------------
module percent_escape_decoder_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  logic [ped_pkg::CP_W-1:0] req_code_point,
   input  logic                     req_end_of_string,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic [ped_pkg::CP_W-1:0] rsp_out_code_point,
   input  logic                     rsp_last_of_run,
   output int                       error_count,
   output int                       pending_beats,
   output int                       chars_seen,
   output int                       beats_seen,
   output int                       groups_decoded,
   output int                       groups_replayed
);
   import ped_pkg::*;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            last;
   } decoded_beat_type;

   decoded_beat_type expected_beats [$];
   phase_type        scan_phase;
   logic [CP_W-1:0]  group_chars [HELD_DEPTH];

   // Returns the digit value in the low four bits and a valid flag on top.
   function automatic logic [4:0] hex_digit(input logic [CP_W-1:0] c);
      logic [CP_W-1:0] t;
      t = '0;
      if (c >= 21'h30 && c <= 21'h39) begin
         t = c - 21'h30;
      end else if (c >= 21'h41 && c <= 21'h46) begin
         t = c - 21'h37;
      end else if (c >= 21'h61 && c <= 21'h66) begin
         t = c - 21'h57;
      end else begin
         return 5'b0;
      end
      return {1'b1, t[3:0]};
   endfunction

   task automatic decode_char(input logic [CP_W-1:0] cp, input logic eos);
      logic [CP_W-1:0]  run [$];
      logic [4:0]       d0, d1, d2, d3;
      int               replay_len;
      decoded_beat_type beat;
      case (scan_phase)
         PH_PCT: begin
            group_chars[1] = cp;
            scan_phase = (cp == CH_LOWER_U) ? PH_U : PH_ONE;
         end
         PH_ONE: begin
            d0 = hex_digit(group_chars[1]);
            d1 = hex_digit(cp);
            if (d0[4] && d1[4]) begin
               run.push_back(CP_W'({d0[3:0], d1[3:0]}));
               groups_decoded++;
            end else begin
               run.push_back(group_chars[0]);
               run.push_back(group_chars[1]);
               run.push_back(cp);
               groups_replayed++;
            end
            scan_phase = PH_IDLE;
         end
         PH_U, PH_U1, PH_U2: begin
            group_chars[int'(scan_phase) - 1] = cp;
            scan_phase = phase_type'(scan_phase + 3'd1);
         end
         PH_U3: begin
            d0 = hex_digit(group_chars[2]);
            d1 = hex_digit(group_chars[3]);
            d2 = hex_digit(group_chars[4]);
            d3 = hex_digit(cp);
            if (d0[4] && d1[4] && d2[4] && d3[4]) begin
               run.push_back(CP_W'({d0[3:0], d1[3:0], d2[3:0], d3[3:0]}));
               groups_decoded++;
            end else begin
               for (int i = 0; i < HELD_DEPTH; i++) begin
                  run.push_back(group_chars[i]);
               end
               run.push_back(cp);
               groups_replayed++;
            end
            scan_phase = PH_IDLE;
         end
         default: begin
            if (cp == CH_PERCENT) begin
               group_chars[0] = cp;
               scan_phase = PH_PCT;
            end else begin
               run.push_back(cp);
            end
         end
      endcase

      // A string that ends inside a group gives back what the group has read.
      if (eos && scan_phase != PH_IDLE) begin
         replay_len = (scan_phase <= PH_ONE) ? int'(scan_phase) : int'(scan_phase) - 1;
         for (int i = 0; i < replay_len; i++) begin
            run.push_back(group_chars[i]);
         end
         groups_replayed++;
         scan_phase = PH_IDLE;
      end

      foreach (run[i]) begin
         beat.code_point = run[i];
         beat.last       = (i == run.size() - 1);
         expected_beats.push_back(beat);
      end
   endtask

   always @(posedge clock) begin : watch
      decoded_beat_type want;
      if (reset) begin
         scan_phase = PH_IDLE;
         expected_beats.delete();
      end else begin
         if (req_valid && req_ready) begin
            chars_seen++;
            decode_char(req_code_point, req_end_of_string);
         end
         if (rsp_valid && rsp_ready) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
               error_count++;
               if (error_count <= 100) begin
                  $display("%0t: unexpected beat: expected none, actual code point %h last %b",
                           $time, rsp_out_code_point, rsp_last_of_run);
               end
            end else begin
               want = expected_beats.pop_front();
               if (want.code_point !== rsp_out_code_point) begin
                  error_count++;
                  if (error_count <= 100) begin
                     $display("%0t: code point mismatch: expected %h, actual %h",
                              $time, want.code_point, rsp_out_code_point);
                  end
               end
               if (want.last !== rsp_last_of_run) begin
                  error_count++;
                  if (error_count <= 100) begin
                     $display("%0t: last-of-run mismatch: expected %b, actual %b",
                              $time, want.last, rsp_last_of_run);
                  end
               end
            end
         end
      end
      pending_beats = expected_beats.size();
   end

endmodule

### verif/percent_escape_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// Percent escape decoder testbench
// Drives escaped strings into the decoder with random gaps and output stalls:
// a short directed set of corner strings, then random strings built from plain
// characters and good, bad and cut escape groups. A checker beside the block scores results.
// ----------------------------------------------------------------------------
module percent_escape_decoder_core_tb;
   import ped_pkg::*;

   localparam int              RANDOM_CHARS = 320;
   localparam int              QUIET_LIMIT  = 1000;
   localparam logic [CP_W-1:0] CH_UPPER_U   = 21'h000055;

   logic clock = 1'b0;
   logic reset;

   ped_req_if req_if ();
   ped_rsp_if rsp_if ();

   int error_count;
   int pending_beats;
   int chars_seen;
   int beats_seen;
   int groups_decoded;
   int groups_replayed;

   int              chars_sent;
   int              quiet_cycles;
   bit              req_steady;
   bit              rsp_steady;
   logic [CP_W-1:0] text_q [$];

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   percent_escape_decoder_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   percent_escape_decoder_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_if.valid),
      .req_ready          (req_if.ready),
      .req_code_point     (req_if.code_point),
      .req_end_of_string  (req_if.end_of_string),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_out_code_point (rsp_if.out_code_point),
      .rsp_last_of_run    (rsp_if.last_of_run),
      .error_count        (error_count),
      .pending_beats      (pending_beats),
      .chars_seen         (chars_seen),
      .beats_seen         (beats_seen),
      .groups_decoded     (groups_decoded),
      .groups_replayed    (groups_replayed)
   );

   function automatic logic [CP_W-1:0] hex_char();
      int v;
      v = $urandom_range(0, 21);
      if (v < 10) begin
         return CP_W'(8'h30 + v);
      end else if (v < 16) begin
         return CP_W'(8'h61 + v - 10);
      end
      return CP_W'(8'h41 + v - 16);
   endfunction

   function automatic logic [CP_W-1:0] non_hex_char();
      case ($urandom_range(0, 4))
         0: return CP_W'($urandom_range(8'h00, 8'h2f));
         1: return CP_W'($urandom_range(8'h3a, 8'h40));
         2: return CP_W'($urandom_range(8'h47, 8'h60));
         3: return CP_W'($urandom_range(8'h67, 8'hff));
         default: return CP_W'($urandom_range(21'h100, 21'h1fffff));
      endcase
   endfunction

   task automatic send_char(input logic [CP_W-1:0] cp, input logic eos);
      int gap;
      if ($urandom_range(0, 39) == 0) begin
         req_steady = !req_steady;
      end
      gap = req_steady ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid      <= 1'b0;
         req_if.code_point <= CP_W'($urandom_range(0, 21'h1fffff));
         repeat (gap) @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.code_point    <= cp;
      req_if.end_of_string <= eos;
      do @(posedge clock); while (!req_if.ready);
      chars_sent++;
   endtask

   task automatic send_text();
      foreach (text_q[i]) begin
         send_char(text_q[i], i == text_q.size() - 1);
      end
      text_q.delete();
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_beats != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : receiver
      int gap;
      rsp_if.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if ($urandom_range(0, 39) == 0) begin
            rsp_steady = !rsp_steady;
         end
         gap = rsp_steady ? 0 : $urandom_range(0, 9);
         @(negedge clock);
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
      end
   end

   initial begin : stimulus
      int pieces;
      int kind;
      int cut;
      int bad;
      int random_base;
      logic [CP_W-1:0] a;
      logic [CP_W-1:0] b;
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.code_point    = '0;
      req_if.end_of_string = 1'b0;
      quiet_cycles         = 0;
      chars_sent           = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Corner strings: plain characters at the field extremes, good and bad
      // groups of both lengths, and strings that end inside a group.
      text_q = '{"a"};                                  send_text();
      text_q = '{21'h000000, 21'h1fffff};               send_text();
      text_q = '{"%", "f", "A"};                        send_text();
      text_q = '{"%", "u", "9", "a", "F", "0"};         send_text();
      text_q = '{"%", "4", "%"};                        send_text();
      text_q = '{"%", "U", "1"};                        send_text();
      text_q = '{"%", "u", "1", "2", 21'h000134, "4"};  send_text();
      text_q = '{"%"};                                  send_text();
      text_q = '{"%", "B"};                             send_text();
      text_q = '{"%", "u", "1"};                        send_text();
      hold_until_drained();

      random_base = chars_sent;
      while (chars_sent < random_base + RANDOM_CHARS) begin
         pieces = $urandom_range(1, 8);
         for (int p = 0; p < pieces; p++) begin
            kind = $urandom_range(0, 99);
            if (p == pieces - 1 && $urandom_range(0, 4) == 0) begin
               // Group cut short by the end of the string.
               text_q.push_back(CH_PERCENT);
               cut = $urandom_range(0, 5);
               if (cut == 1) begin
                  text_q.push_back(hex_char());
               end else if (cut >= 2) begin
                  text_q.push_back(CH_LOWER_U);
                  repeat (cut - 2) text_q.push_back(hex_char());
               end
            end else if (kind < 30) begin
               case ($urandom_range(0, 3))
                  0: text_q.push_back(CP_W'($urandom_range(8'h20, 8'h7e)));
                  1: text_q.push_back(hex_char());
                  2: text_q.push_back(CP_W'($urandom_range(0, 16'hffff)));
                  default: text_q.push_back(CP_W'($urandom_range(0, 21'h1fffff)));
               endcase
            end else if (kind < 55) begin
               text_q.push_back(CH_PERCENT);
               repeat (2) text_q.push_back(hex_char());
            end else if (kind < 75) begin
               text_q.push_back(CH_PERCENT);
               text_q.push_back(CH_LOWER_U);
               repeat (4) text_q.push_back(hex_char());
            end else if (kind < 87) begin
               case ($urandom_range(0, 2))
                  0: begin
                     a = non_hex_char();
                     b = hex_char();
                  end
                  1: begin
                     a = hex_char();
                     b = non_hex_char();
                  end
                  default: begin
                     a = non_hex_char();
                     b = ($urandom_range(0, 3) == 0) ? CH_PERCENT : non_hex_char();
                  end
               endcase
               if (a == CH_LOWER_U) begin
                  a = CH_UPPER_U;
               end
               text_q.push_back(CH_PERCENT);
               text_q.push_back(a);
               text_q.push_back(b);
            end else begin
               bad = $urandom_range(0, 3);
               text_q.push_back(CH_PERCENT);
               text_q.push_back(CH_LOWER_U);
               for (int j = 0; j < 4; j++) begin
                  text_q.push_back((j == bad || $urandom_range(0, 3) == 0) ?
                                   non_hex_char() : hex_char());
               end
            end
         end
         send_text();
         if ($urandom_range(0, 11) == 0) begin
            hold_until_drained();
         end
      end

      hold_until_drained();
      repeat (20) @(negedge clock);

      $display("Sent %0d characters and checked %0d result beats.", chars_seen, beats_seen);
      $display("Escape groups decoded: %0d, replayed unchanged: %0d.",
               groups_decoded, groups_replayed);
      if (error_count == 0 && pending_beats == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
